// ===== hdl/mpbm_pkg.sv =====
`default_nettype none

package mpbm_pkg;

    // Command codes carried in the input tuser.
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_SCAN  = 2'd1;
    localparam logic [1:0] CMD_NEW   = 2'd2;

    localparam int NODE_W = 12;
    localparam int BYTE_W = 8;
    localparam int ID_W   = 16;
    localparam int OFF_W  = 16;

    localparam int SIB_CNT_W = 8;
    localparam logic [SIB_CNT_W-1:0] SIB_CNT_LAST = '1;
    localparam logic [OFF_W-1:0] OFF_MAX = '1;

    // Link word of one trie node, first child in the lowest bits.
    typedef struct packed {
        logic [NODE_W-1:0] rep;
        logic [NODE_W-1:0] fail;
        logic [NODE_W-1:0] sib;
        logic [NODE_W-1:0] child;
    } link_t;

    // Tag word of one trie node, edge byte in the lowest bits.
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic              is_end;
        logic [BYTE_W-1:0] ch;
    } tag_t;

    typedef struct packed {
        logic [1:0]        command;
        logic [NODE_W-1:0] node_index;
        tag_t              tag;
        link_t             link;
        logic [BYTE_W-1:0] text_byte;
    } in_item_t;

    // Node store access from the sequencer.
    typedef struct packed {
        logic              we;
        logic [NODE_W-1:0] waddr;
        logic              re;
        logic [NODE_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic             found;
        logic [ID_W-1:0]  id;
        logic [OFF_W-1:0] off;
        logic             last;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACK,
        ST_FETCH,
        ST_SIB,
        ST_REP,
        ST_NOMATCH,
        ST_FLUSH
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/mpbm_ram.sv =====
`default_nettype none

module mpbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/mpbm_seq.sv =====
`default_nettype none

module mpbm_seq
    import mpbm_pkg::*;
#(
    parameter int MAX_PATTERN_LEN = 34
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_item_t in_item,
    output mem_req_t      mem_req,
    input  wire link_t    link_rd,
    input  wire tag_t     tag_rd,
    output logic          out_valid,
    input  wire logic     out_ready,
    output result_t       out_res
);

    localparam int SW = $clog2(MAX_PATTERN_LEN + 2);
    localparam logic [SW-1:0] MAXV = SW'(MAX_PATTERN_LEN);

    state_t state_reg, state_next;

    logic [NODE_W-1:0]    cur_reg, cur_next;
    logic [OFF_W-1:0]     boff_reg, boff_next;
    logic [BYTE_W-1:0]    b_reg, b_next;
    logic [OFF_W-1:0]     off_reg, off_next;
    logic [NODE_W-1:0]    node_reg, node_next;
    logic [NODE_W-1:0]    fail_reg, fail_next;
    logic [NODE_W-1:0]    p_reg, p_next;
    logic [SIB_CNT_W-1:0] sib_cnt_reg, sib_cnt_next;
    logic [SW-1:0]        steps_reg, steps_next;
    logic [SW-1:0]        rep_cnt_reg, rep_cnt_next;
    logic [SW-1:0]        n_reg, n_next;
    logic                 pend_reg, pend_next;
    logic [ID_W-1:0]      pend_id_reg, pend_id_next;
    logic                 out_valid_reg;
    result_t              out_res_reg;

    logic                 out_free;
    logic                 push;
    result_t              push_res;
    logic                 accept;
    logic                 sib_hit;
    logic                 sib_stop;
    logic [NODE_W-1:0]    fail_src;
    logic [NODE_W-1:0]    miss_node;
    logic [SW-1:0]        n_first;
    logic                 rep_go_first;
    logic [SW-1:0]        n_rep;
    logic                 rep_go;
    logic                 rep_stall;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    // Shared decisions of the walk over the node store.
    always_comb
    begin
        sib_hit      = (tag_rd.ch == b_reg);
        sib_stop     = (link_rd.sib == '0) || (sib_cnt_reg == SIB_CNT_LAST);
        fail_src     = (state_reg == ST_FETCH) ? link_rd.fail : fail_reg;
        miss_node    = (steps_reg >= MAXV) ? '0 : fail_src;
        n_first      = tag_rd.is_end ? SW'(1) : '0;
        rep_go_first = (link_rd.rep != '0) && (n_first < MAXV);
        n_rep        = n_reg + (tag_rd.is_end ? SW'(1) : '0);
        rep_go       = (link_rd.rep != '0) && ((rep_cnt_reg + SW'(1)) < MAXV)
                       && (n_rep < MAXV);
        rep_stall    = tag_rd.is_end && pend_reg && !out_free;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_item.command == CMD_SCAN) ? ST_FETCH : ST_ACK;
                end
            end
            ST_ACK, ST_NOMATCH, ST_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FETCH:
            begin
                if (link_rd.child != '0)
                begin
                    state_next = ST_SIB;
                end
                else if (node_reg == '0)
                begin
                    state_next = ST_NOMATCH;
                end
            end
            ST_SIB:
            begin
                if (sib_hit)
                begin
                    if (rep_go_first)
                    begin
                        state_next = ST_REP;
                    end
                    else
                    begin
                        state_next = tag_rd.is_end ? ST_FLUSH : ST_NOMATCH;
                    end
                end
                else if (sib_stop)
                begin
                    state_next = (node_reg == '0) ? ST_NOMATCH : ST_FETCH;
                end
            end
            ST_REP:
            begin
                if (!rep_stall && !rep_go)
                begin
                    state_next = (pend_reg || tag_rd.is_end) ? ST_FLUSH : ST_NOMATCH;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, node store requests and result pushes.
    always_comb
    begin
        cur_next     = cur_reg;
        boff_next    = boff_reg;
        b_next       = b_reg;
        off_next     = off_reg;
        node_next    = node_reg;
        fail_next    = fail_reg;
        p_next       = p_reg;
        sib_cnt_next = sib_cnt_reg;
        steps_next   = steps_reg;
        rep_cnt_next = rep_cnt_reg;
        n_next       = n_reg;
        pend_next    = pend_reg;
        pend_id_next = pend_id_reg;
        mem_req      = '0;
        push         = 1'b0;
        push_res     = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_item.command)
                        CMD_WRITE:
                        begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = in_item.node_index;
                        end
                        CMD_SCAN:
                        begin
                            b_next       = in_item.text_byte;
                            off_next     = boff_reg;
                            boff_next    = (boff_reg == OFF_MAX) ? boff_reg
                                                                 : boff_reg + OFF_W'(1);
                            node_next    = cur_reg;
                            steps_next   = '0;
                            mem_req.re    = 1'b1;
                            mem_req.raddr = cur_reg;
                        end
                        CMD_NEW:
                        begin
                            cur_next  = '0;
                            boff_next = '0;
                        end
                        default:
                        begin
                            cur_next = cur_reg;
                        end
                    endcase
                end
            end
            ST_ACK:
            begin
                push          = out_free;
                push_res.last = 1'b1;
            end
            ST_FETCH:
            begin
                fail_next = link_rd.fail;
                if (link_rd.child != '0)
                begin
                    p_next        = link_rd.child;
                    sib_cnt_next  = '0;
                    mem_req.re    = 1'b1;
                    mem_req.raddr = link_rd.child;
                end
                else if (node_reg != '0)
                begin
                    node_next     = miss_node;
                    steps_next    = steps_reg + SW'(1);
                    mem_req.re    = 1'b1;
                    mem_req.raddr = miss_node;
                end
                else
                begin
                    cur_next = '0;
                end
            end
            ST_SIB:
            begin
                if (sib_hit)
                begin
                    cur_next     = p_reg;
                    pend_next    = tag_rd.is_end;
                    pend_id_next = tag_rd.id;
                    n_next       = n_first;
                    rep_cnt_next = '0;
                    if (rep_go_first)
                    begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = link_rd.rep;
                    end
                end
                else if (!sib_stop)
                begin
                    p_next        = link_rd.sib;
                    sib_cnt_next  = sib_cnt_reg + SIB_CNT_W'(1);
                    mem_req.re    = 1'b1;
                    mem_req.raddr = link_rd.sib;
                end
                else if (node_reg != '0)
                begin
                    node_next     = miss_node;
                    steps_next    = steps_reg + SW'(1);
                    mem_req.re    = 1'b1;
                    mem_req.raddr = miss_node;
                end
                else
                begin
                    cur_next = '0;
                end
            end
            ST_REP:
            begin
                if (!rep_stall)
                begin
                    if (tag_rd.is_end)
                    begin
                        // The held match is not the last one: send it now.
                        push           = pend_reg;
                        push_res.found = 1'b1;
                        push_res.id    = pend_id_reg;
                        push_res.off   = off_reg;
                        pend_next      = 1'b1;
                        pend_id_next   = tag_rd.id;
                        n_next         = n_rep;
                    end
                    rep_cnt_next = rep_cnt_reg + SW'(1);
                    if (rep_go)
                    begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = link_rd.rep;
                    end
                end
            end
            ST_NOMATCH:
            begin
                push          = out_free;
                push_res.off  = off_reg;
                push_res.last = 1'b1;
            end
            ST_FLUSH:
            begin
                push           = out_free;
                push_res.found = 1'b1;
                push_res.id    = pend_id_reg;
                push_res.off   = off_reg;
                push_res.last  = 1'b1;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_reg       <= '0;
            boff_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            boff_reg  <= boff_next;
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers of the walk.
    always_ff @(posedge clk)
    begin
        b_reg       <= b_next;
        off_reg     <= off_next;
        node_reg    <= node_next;
        fail_reg    <= fail_next;
        p_reg       <= p_next;
        sib_cnt_reg <= sib_cnt_next;
        steps_reg   <= steps_next;
        rep_cnt_reg <= rep_cnt_next;
        n_reg       <= n_next;
        pend_reg    <= pend_next;
        pend_id_reg <= pend_id_next;
        if (push)
        begin
            out_res_reg <= push_res;
        end
    end

    // A result is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> out_free)
        else $error("result loaded while output still full");

    // A no-match or acknowledgement always closes its item.
    a_nomatch_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_res_reg.found) |-> out_res_reg.last)
        else $error("non-match result without last");

    // Non-scan commands are answered by a single acknowledgement.
    a_cmd_ack: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_item.command != CMD_SCAN) |=> state_reg == ST_ACK)
        else $error("non-scan command did not go to acknowledgement");

    // Report count stays within the per-byte limit.
    a_n_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REP) |-> (n_reg <= MAXV))
        else $error("too many results for one byte");

endmodule

`default_nettype wire

// ===== hdl/multi_pattern_byte_matcher_top.sv =====
// A write, new-text or unknown item is answered by one acknowledgement, pushed from the
// acknowledgement state once the output register is free. A scan byte presents its last
// result after one node store read of its current node, one per sibling visited, per
// failure step and per report chain step; a stalled receiver delays it. One item at a
// time: a new item is accepted only in the idle state.
// Reset (rst_n, asynchronous, active low) returns to the root node and offset zero;
// the node store is not cleared and must be written before it is used.
`default_nettype none

module multi_pattern_byte_matcher_top
    import mpbm_pkg::*;
#(
    parameter int NODE_COUNT      = 4096,
    parameter int MAX_PATTERN_LEN = 34
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // node_index, node_char, first_child, next_sibling, fail_link, report_link,
    // is_pattern_end, pattern_id, text_byte, zero pad
    input  wire logic [95:0] s_tdata,
    // command
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // match_id, end_offset
    output logic [31:0]      m_tdata,
    // found
    output logic [0:0]       m_tuser,
    output logic             m_tlast
);

    localparam int MEM_DEPTH = (NODE_COUNT < 4096) ? NODE_COUNT : 4096;
    localparam int AW        = $clog2(MEM_DEPTH);

    in_item_t item;
    mem_req_t mem_req;
    link_t    link_raw;
    tag_t     tag_raw;
    link_t    link_rd;
    tag_t     tag_rd;
    result_t  res;
    logic     wr_ok;
    logic     rd_ok;
    logic     rd_ok_reg;

    // Unpack the input item.
    always_comb
    begin
        item.command    = s_tuser;
        item.node_index = s_tdata[11:0];
        item.tag.ch     = s_tdata[19:12];
        item.link.child = s_tdata[31:20];
        item.link.sib   = s_tdata[43:32];
        item.link.fail  = s_tdata[55:44];
        item.link.rep   = s_tdata[67:56];
        item.tag.is_end = s_tdata[68];
        item.tag.id     = s_tdata[84:69];
        item.text_byte  = s_tdata[92:85];
    end

    // Nodes beyond the store are never written and read as zeros.
    assign wr_ok = ({20'd0, mem_req.waddr} < 32'(NODE_COUNT));
    assign rd_ok = ({20'd0, mem_req.raddr} < 32'(NODE_COUNT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ok_reg <= 1'b0;
        end
        else if (mem_req.re)
        begin
            rd_ok_reg <= rd_ok;
        end
    end

    assign link_rd = rd_ok_reg ? link_raw : '0;
    assign tag_rd  = rd_ok_reg ? tag_raw : '0;

    mpbm_ram #(
        .WIDTH($bits(link_t)),
        .DEPTH(MEM_DEPTH)
    ) u_link_ram (
        .clk  (clk),
        .we   (mem_req.we && wr_ok),
        .waddr(mem_req.waddr[AW-1:0]),
        .wdata(item.link),
        .re   (mem_req.re),
        .raddr(mem_req.raddr[AW-1:0]),
        .rdata(link_raw)
    );

    mpbm_ram #(
        .WIDTH($bits(tag_t)),
        .DEPTH(MEM_DEPTH)
    ) u_tag_ram (
        .clk  (clk),
        .we   (mem_req.we && wr_ok),
        .waddr(mem_req.waddr[AW-1:0]),
        .wdata(item.tag),
        .re   (mem_req.re),
        .raddr(mem_req.raddr[AW-1:0]),
        .rdata(tag_raw)
    );

    mpbm_seq #(
        .MAX_PATTERN_LEN(MAX_PATTERN_LEN)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (item),
        .mem_req  (mem_req),
        .link_rd  (link_rd),
        .tag_rd   (tag_rd),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_res  (res)
    );

    // Pack the result item.
    assign m_tdata = {res.off, res.id};
    assign m_tuser = res.found;
    assign m_tlast = res.last;

endmodule

`default_nettype wire

// ===== test/tb_multi_pattern_byte_matcher_checker.sv =====
`default_nettype none

module tb_multi_pattern_byte_matcher_checker
    import mpbm_pkg::*;
#(
    parameter int MAX_STEPS = 34
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [95:0] s_tdata,
    input  wire logic [1:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    input  wire logic [0:0]  m_tuser,
    input  wire logic        m_tlast,
    output int               errors,
    output int               pending
);

    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the node store and the scan position.
    link_t             node_links [4096];
    tag_t              node_tags  [4096];
    logic [NODE_W-1:0] cur_node;
    logic [OFF_W-1:0]  text_pos;

    result_t expected_results[$];

    assign pending = expected_results.size();

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        errors++;
    endtask

    // Walks the sibling list of a node for a child labeled with the byte.
    function automatic logic [NODE_W-1:0] child_with(logic [NODE_W-1:0] n,
                                                     logic [BYTE_W-1:0] b);
        logic [NODE_W-1:0] p;
        int                k;
        p = node_links[n].child;
        k = 0;
        while (p != 0 && k < 256)
        begin
            if (node_tags[p].ch == b)
                return p;
            p = node_links[p].sib;
            k++;
        end
        return '0;
    endfunction

    task automatic push_result(logic found, logic [ID_W-1:0] id, logic [OFF_W-1:0] off,
                               logic last);
        result_t r;
        r.found = found;
        r.id    = id;
        r.off   = off;
        r.last  = last;
        expected_results.push_back(r);
    endtask

    // Scans one text byte and queues the patterns that end on it, within the MAX_STEPS limits.
    task automatic scan_byte(logic [BYTE_W-1:0] b);
        logic [OFF_W-1:0]  off;
        logic [NODE_W-1:0] n;
        logic [NODE_W-1:0] hit;
        logic [NODE_W-1:0] c;
        int                steps;
        int                k;
        int                count;
        int                first;
        off   = text_pos;
        n     = cur_node;
        hit   = '0;
        steps = 0;
        count = 0;
        first = expected_results.size();
        if (text_pos != OFF_MAX)
            text_pos++;
        while (1)
        begin
            c = child_with(n, b);
            if (c != 0)
            begin
                hit = c;
                break;
            end
            if (n == 0)
                break;
            n = (steps >= MAX_STEPS) ? '0 : node_links[n].fail;
            steps++;
        end
        cur_node = hit;
        if (hit != 0)
        begin
            if (node_tags[hit].is_end)
            begin
                push_result(1'b1, node_tags[hit].id, off, 1'b0);
                count++;
            end
            n = node_links[hit].rep;
            k = 0;
            while (n != 0 && k < MAX_STEPS && count < MAX_STEPS)
            begin
                if (node_tags[n].is_end)
                begin
                    push_result(1'b1, node_tags[n].id, off, 1'b0);
                    count++;
                end
                n = node_links[n].rep;
                k++;
            end
        end
        if (count == 0)
            push_result(1'b0, '0, off, 1'b1);
        else
            expected_results[first + count - 1].last = 1'b1;
    endtask

    // Predicts on each accepted input item and checks each accepted result item.
    always @(posedge clk or negedge rst_n)
    begin
        result_t           want;
        logic [NODE_W-1:0] idx;
        if (!rst_n)
        begin
            cur_node = '0;
            text_pos = '0;
            expected_results.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == CMD_SCAN)
                    scan_byte(s_tdata[92:85]);
                else
                begin
                    if (s_tuser == CMD_WRITE)
                    begin
                        idx = s_tdata[11:0];
                        node_tags[idx].ch      = s_tdata[19:12];
                        node_links[idx].child  = s_tdata[31:20];
                        node_links[idx].sib    = s_tdata[43:32];
                        node_links[idx].fail   = s_tdata[55:44];
                        node_links[idx].rep    = s_tdata[67:56];
                        node_tags[idx].is_end  = s_tdata[68];
                        node_tags[idx].id      = s_tdata[84:69];
                    end
                    else if (s_tuser == CMD_NEW)
                    begin
                        cur_node = '0;
                        text_pos = '0;
                    end
                    push_result(1'b0, '0, '0, 1'b1);
                end
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result item with nothing expected");
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tuser[0] !== want.found)
                        report_mismatch($sformatf("found %b, expected %b", m_tuser[0], want.found));
                    if (m_tdata[15:0] !== want.id)
                        report_mismatch($sformatf("match_id %h, expected %h",
                                                  m_tdata[15:0], want.id));
                    if (m_tdata[31:16] !== want.off)
                        report_mismatch($sformatf("end_offset %0d, expected %0d",
                                                  m_tdata[31:16], want.off));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("last %b, expected %b", m_tlast, want.last));
                end
            end
        end
    end

    initial errors = 0;

endmodule

`default_nettype wire

// ===== test/tb_multi_pattern_byte_matcher_top.sv =====
`default_nettype none

module tb_multi_pattern_byte_matcher_top
    import mpbm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL_SIZE  = 40;
    localparam int STALL_HOLD = 400;
    localparam int WATCH_MAX  = 50000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;
    int          errors;
    int          pending;

    // Only nodes in this set are ever written or linked, so no unwritten
    // entry is read.
    logic [NODE_W-1:0] trie_nodes [POOL_SIZE];
    logic [BYTE_W-1:0] alphabet   [4];
    bit                sender_gaps;
    bit                receiver_gaps;
    bit                hold_output;
    int                quiet_cycles;

    multi_pattern_byte_matcher_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    tb_multi_pattern_byte_matcher_checker checker_inst (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .errors   (errors),
        .pending  (pending)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Offers one item and holds it until it is accepted.
    task automatic send_item(logic [1:0] cmd, logic [NODE_W-1:0] idx, logic [BYTE_W-1:0] ch,
                             logic [NODE_W-1:0] child, logic [NODE_W-1:0] sib,
                             logic [NODE_W-1:0] fail, logic [NODE_W-1:0] rep,
                             logic is_end, logic [ID_W-1:0] id, logic [BYTE_W-1:0] b);
        while (sender_gaps && $urandom_range(99) < 23)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = {3'b000, b, id, is_end, rep, fail, sib, child, ch, idx};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic scan(logic [BYTE_W-1:0] b);
        send_item(CMD_SCAN, NODE_W'($urandom), BYTE_W'($urandom), NODE_W'($urandom),
                  NODE_W'($urandom), NODE_W'($urandom), NODE_W'($urandom),
                  1'($urandom), ID_W'($urandom), b);
    endtask

    task automatic control(logic [1:0] cmd);
        send_item(cmd, NODE_W'($urandom), BYTE_W'($urandom), NODE_W'($urandom),
                  NODE_W'($urandom), NODE_W'($urandom), NODE_W'($urandom),
                  1'($urandom), ID_W'($urandom), BYTE_W'($urandom));
    endtask

    function automatic logic [NODE_W-1:0] pick_node(int zero_pct);
        if ($urandom_range(99) < zero_pct)
            return '0;
        return trie_nodes[$urandom_range(POOL_SIZE - 1)];
    endfunction

    // Writes one node of the set with random links that stay inside the set.
    task automatic write_node(logic [NODE_W-1:0] idx);
        send_item(CMD_WRITE, idx, alphabet[$urandom_range(3)], pick_node(20),
                  pick_node(35), pick_node(40), pick_node(50), 1'($urandom),
                  ID_W'($urandom), BYTE_W'($urandom));
    endtask

    task automatic random_items(int count);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 72)
                scan(alphabet[$urandom_range(3)]);
            else if (r < 78)
                scan(BYTE_W'($urandom));
            else if (r < 90)
                write_node(trie_nodes[$urandom_range(POOL_SIZE - 1)]);
            else if (r < 96)
                control(CMD_NEW);
            else
                control(2'd3);
        end
    endtask

    // Receiver: random stalls, or a long hold-off on request.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_output)
            begin
                m_tready = 1'b0;
                repeat (STALL_HOLD) @(negedge clk);
                hold_output = 1'b0;
            end
            m_tready = !(receiver_gaps && $urandom_range(99) < 23);
        end
    end

    // Watchdog on cycles in which neither side moves an item.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_MAX)
        begin
            $display("tb_multi_pattern_byte_matcher_top failed");
            $finish;
        end
    end

    initial
    begin
        logic [NODE_W-1:0] cand;
        bit                dup;
        quiet_cycles  = 0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = CMD_WRITE;
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
        hold_output   = 1'b0;
        rst_n         = 1'b0;

        // Node set: root, the extreme indexes, and random others.
        trie_nodes[0] = 12'h000;
        trie_nodes[1] = 12'hFFF;
        trie_nodes[2] = 12'h001;
        trie_nodes[3] = 12'h800;
        for (int i = 4; i < POOL_SIZE; i++)
        begin
            do
            begin
                cand = NODE_W'($urandom_range(4094, 2));
                dup  = 1'b0;
                for (int j = 0; j < i; j++)
                    if (trie_nodes[j] == cand)
                        dup = 1'b1;
            end
            while (dup);
            trie_nodes[i] = cand;
        end
        alphabet[0] = 8'h00;
        alphabet[1] = 8'hFF;
        alphabet[2] = BYTE_W'($urandom);
        alphabet[3] = BYTE_W'($urandom);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Load every node of the set before any scan.
        for (int i = 0; i < POOL_SIZE; i++)
            write_node(trie_nodes[i]);

        // Directed: extreme field values, every command, chains of matches.
        send_item(CMD_WRITE, 12'hFFF, 8'hFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
                  1'b1, 16'hFFFF, 8'hFF);
        send_item(CMD_WRITE, 12'h001, 8'h00, 12'h000, 12'h000, 12'h000, 12'h000,
                  1'b0, 16'h0000, 8'h00);
        send_item(CMD_WRITE, 12'h000, 8'h00, 12'hFFF, 12'h000, 12'h000, 12'h000,
                  1'b0, 16'h0000, 8'h00);
        scan(8'hFF);
        scan(8'hFF);
        scan(8'h00);
        scan(8'hFF);
        control(2'd3);
        control(CMD_NEW);
        scan(8'h00);
        scan(8'hFF);
        send_item(CMD_WRITE, 12'h800, 8'hFF, 12'h000, 12'h000, 12'hFFF, 12'h800,
                  1'b1, 16'h1234, 8'h00);
        send_item(CMD_WRITE, 12'h000, 8'hA5, 12'h800, 12'h000, 12'h000, 12'h000,
                  1'b0, 16'h0000, 8'h00);
        scan(8'hFF);
        scan(8'hFF);
        scan(8'h5A);
        scan(8'hA5);
        control(CMD_NEW);

        // Random phase with long gap-free stretch and a receiver hold-off.
        for (int i = 0; i < POOL_SIZE; i++)
            write_node(trie_nodes[i]);
        random_items(90);
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
        hold_output   = 1'b1;
        random_items(90);
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;

        // Second trie over a fresh alphabet.
        for (int i = 0; i < 4; i++)
            alphabet[i] = BYTE_W'($urandom);
        for (int i = 0; i < POOL_SIZE; i++)
            write_node(trie_nodes[i]);
        random_items(90);

        // A childless root drops every byte, then the root is reloaded.
        control(CMD_NEW);
        send_item(CMD_WRITE, 12'h000, 8'h00, 12'h000, 12'h000, 12'h000, 12'h000,
                  1'b0, 16'h0000, 8'h00);
        for (int i = 0; i < 10; i++)
            scan(BYTE_W'($urandom));
        write_node(12'h000);
        for (int i = 0; i < 20; i++)
            scan(alphabet[$urandom_range(3)]);

        // Drain and give the verdict.
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("tb_multi_pattern_byte_matcher_top passed");
        else
            $display("tb_multi_pattern_byte_matcher_top failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/mpbm_pkg.sv
hdl/mpbm_ram.sv
hdl/mpbm_seq.sv
hdl/multi_pattern_byte_matcher_top.sv
test/tb_multi_pattern_byte_matcher_checker.sv
test/tb_multi_pattern_byte_matcher_top.sv
